>>> design/lars_pkg.sv
// Package for the row-streaming life automaton: shared types, register
// offsets, reset values and the neighbor count helper. No dependencies.
`timescale 1ns / 1ps

package lars_pkg;

  localparam int unsigned ROW_W      = 64;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WORD_W     = ROW_W + 1;

  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  localparam logic [3:0] LOWER_RST = 4'd3;
  localparam logic [3:0] UPPER_RST = 4'd6;
  localparam logic [6:0] COLS_RST  = 7'd55;

  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } col_bits_t;

  typedef struct packed {
    logic load;
    logic flush;
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0] lower;
    logic [3:0] upper;
    logic       ok;
  } rule_t;

  function automatic logic [3:0] count8(input logic [7:0] bits);
    logic [3:0] acc;
    acc = 4'd0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + {3'b000, bits[i]};
    end
    return acc;
  endfunction

endpackage

>>> design/lars_cell.sv
// One column cell: holds the column's bits of the two held rows and
// computes the column's next-generation bit. Depends on lars_pkg.
`timescale 1ns / 1ps

module lars_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lars_pkg::cell_ctrl_t ctrl_i,
  input  lars_pkg::rule_t     rule_i,
  input  logic                en_i,
  input  logic                row_bit_i,
  input  lars_pkg::col_bits_t left_i,
  input  lars_pkg::col_bits_t right_i,
  output lars_pkg::col_bits_t own_o,
  output logic                next_o
);
  import lars_pkg::*;

  logic       above_q, above_d;
  logic       mid_q, mid_d;
  logic [3:0] cnt;

  assign own_o.up  = above_q & en_i;
  assign own_o.mid = mid_q & en_i;
  assign own_o.dn  = row_bit_i & en_i & ~ctrl_i.flush;

  assign cnt = count8({left_i.up, left_i.mid, left_i.dn, own_o.up, own_o.dn,
                       right_i.up, right_i.mid, right_i.dn});

  assign next_o = rule_i.ok & en_i & (cnt > rule_i.lower) & (cnt <= rule_i.upper);

  always_comb begin
    above_d = above_q;
    mid_d   = mid_q;
    if (ctrl_i.flush) begin
      above_d = 1'b0;
      mid_d   = 1'b0;
    end else if (ctrl_i.load) begin
      above_d = mid_q;
      mid_d   = row_bit_i & en_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      mid_q   <= 1'b0;
    end else begin
      above_q <= above_d;
      mid_q   <= mid_d;
    end
  end

endmodule

>>> design/lars_out_fifo.sv
// Two-word result queue between the cell row and the output stream.
// Depends on lars_pkg only for the import convention.
`timescale 1ns / 1ps

module lars_out_fifo #(
  parameter int unsigned Width = 65
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);
  import lars_pkg::*;

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;
  assign free_o  = (cnt_q != 2'd2) | ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/life_automaton_row_step.sv
// Top level of the row-streaming life automaton: config registers, row
// of column cells, grid sequencing and result queue. Uses lars_pkg,
// lars_cell and lars_out_fifo.
//
//   channel  | dir | data                         | side band
//   s_axis   | in  | tdata[63:0] row_bits         | tlast = last_row
//   m_axis   | out | tdata[63:0] next_row         | tlast = last_out
//   apb      | in  | 0x0 lower, 0x4 upper, 0x8 cols | pready tied high
//
// One row word is taken per cycle; its result (from the second row of a
// grid on) enters the two-word output queue in the same cycle.
// After a last row the cell row flushes the final result and clears;
// no word is taken while that flush is pending.
// Input also stalls, and a pending flush waits, while the output queue is
// full and not being drained.
// Reset clears the held rows, the queue and the registers to 3, 6 and 55.
`timescale 1ns / 1ps

module life_automaton_row_step #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] row_bits
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] next_row
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lars_pkg::*;

  logic [3:0]        lower_q;
  logic [3:0]        upper_q;
  logic [6:0]        cols_q;
  logic              has_row_q, has_row_d;
  logic              flush_q, flush_d;
  logic              cfg_wr;
  logic              accept;
  logic              flush_go;
  logic              q_free;
  logic              push;
  logic [ROW_W-1:0]  next_row;
  logic [WORD_W-1:0] q_out;
  rule_t             rule;
  cell_ctrl_t        ctrl;
  col_bits_t         nb [MAX_COLS+2];

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RST;
      upper_q <= UPPER_RST;
      cols_q  <= COLS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOWER: lower_q <= pwdata[3:0];
        REG_UPPER: upper_q <= pwdata[3:0];
        REG_COLS:  cols_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOWER: prdata = {28'd0, lower_q};
      REG_UPPER: prdata = {28'd0, upper_q};
      REG_COLS:  prdata = {25'd0, cols_q};
      default:   prdata = '0;
    endcase
  end

  assign rule.lower = lower_q;
  assign rule.upper = upper_q;
  assign rule.ok    = (lower_q != 4'd0) & (upper_q != 4'd0) & (lower_q <= upper_q);

  assign s_axis_tready = ~flush_q & q_free;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign flush_go      = flush_q & q_free;
  assign ctrl.load     = accept;
  assign ctrl.flush    = flush_go;
  assign push          = (accept & has_row_q) | flush_go;

  always_comb begin
    has_row_d = has_row_q;
    flush_d   = flush_q;
    if (flush_go) begin
      has_row_d = 1'b0;
      flush_d   = 1'b0;
    end else if (accept) begin
      has_row_d = 1'b1;
      flush_d   = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_row_q <= 1'b0;
      flush_q   <= 1'b0;
    end else begin
      has_row_q <= has_row_d;
      flush_q   <= flush_d;
    end
  end

  assign nb[0]          = '0;
  assign nb[MAX_COLS+1] = '0;

  for (genvar g = 0; g < ROW_W; g++) begin : g_col
    if (g < MAX_COLS) begin : g_cell
      lars_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .rule_i   (rule),
        .en_i     (cols_q > 7'(g)),
        .row_bit_i(s_axis_tdata[g]),
        .left_i   (nb[g]),
        .right_i  (nb[g+2]),
        .own_o    (nb[g+1]),
        .next_o   (next_row[g])
      );
    end else begin : g_unused
      assign next_row[g] = 1'b0;
    end
  end

  lars_out_fifo #(
    .Width(WORD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({flush_go, next_row}),
    .free_o (q_free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (q_out)
  );

  assign m_axis_tdata = q_out[ROW_W-1:0];
  assign m_axis_tlast = q_out[ROW_W];

endmodule

>>> design/lars_checker.sv
// Port-level checks for life_automaton_row_step, attached by bind.
// Depends on lars_pkg and the top level's port list.
`timescale 1ns / 1ps

module lars_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import lars_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid & s_axis_tready;

  // last row is followed by a flush cycle that takes no word
  a_flush_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> !s_axis_tready)
    else $error("word taken in flush cycle after last row");

  // input back-pressure only from a flush or a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
                    || $past(in_acc && s_axis_tlast)
                    || $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

endmodule

bind life_automaton_row_step lars_checker u_lars_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
